### hw/rtl/point_in_tetrahedron_test_top_defines.svh
// ---------------------------------------------------------------------------
// point_in_tetrahedron_test_top_defines
// assertion macros used by the checker file of the tetrahedron test block
// ---------------------------------------------------------------------------
`ifndef POINT_IN_TETRAHEDRON_TEST_TOP_DEFINES_SVH
`define POINT_IN_TETRAHEDRON_TEST_TOP_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define PIT_ASSERT_IMP(name, clock, rst_n, ante, cons) \
	name: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pit assertion failed");

// next-cycle implication, checked while out of reset
`define PIT_ASSERT_NXT(name, clock, rst_n, ante, cons) \
	name: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pit assertion failed");

`endif

### hw/rtl/pit_pkg.sv
// ---------------------------------------------------------------------------
// pit_pkg
// widths, types and command codes of the point-in-tetrahedron test block
// ---------------------------------------------------------------------------
`default_nettype none

package pit_pkg;

	localparam int COORD_WIDTH = 21;
	localparam int NUM_VERTS   = 4;
	localparam int NUM_AXES    = 3;

	// difference of two coordinates
	localparam int DW   = COORD_WIDTH + 1;
	// product of two differences
	localparam int PW   = 2 * DW;
	// 2x2 minor
	localparam int MW   = PW + 1;
	// minor split for the second multiplication
	localparam int LO_W = DW + 1;
	localparam int HI_W = MW - LO_W;
	localparam int PLW  = DW + LO_W + 1;
	localparam int PHW  = DW + HI_W;
	// cofactor term and full determinant
	localparam int TW   = DW + MW;
	localparam int DETW = TW + 2;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TEST = 1'b1;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [DW-1:0]          diff_t;
	typedef logic signed [PW-1:0]          prod_t;
	typedef logic signed [MW-1:0]          minor_t;
	typedef logic        [LO_W-1:0]        minor_lo_t;
	typedef logic signed [PLW-1:0]         plo_t;
	typedef logic signed [PHW-1:0]         phi_t;
	typedef logic signed [TW-1:0]          term_t;
	typedef logic signed [DETW-1:0]        det_t;

endpackage

`default_nettype wire

### hw/rtl/point_in_tetrahedron_test_top.sv
// ---------------------------------------------------------------------------
// point_in_tetrahedron_test_top
// tests points against a loaded tetrahedron by the signs of four determinants
// ---------------------------------------------------------------------------
// a test result passes the stage registers s1 to s6 and leaves the output from s6
// throughput: one transaction per cycle unless out_ready stalls the six-stage multiply pipeline
// loads write the vertex registers at acceptance and produce no result
// reset clears all valid bits; vertex registers hold no reset value
// ---------------------------------------------------------------------------
`default_nettype none

module point_in_tetrahedron_test_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic                             command,
	input  wire logic [1:0]                       vertex_index,
	input  wire logic signed [pit_pkg::COORD_WIDTH-1:0] pos_z,
	input  wire logic signed [pit_pkg::COORD_WIDTH-1:0] pos_y,
	input  wire logic signed [pit_pkg::COORD_WIDTH-1:0] pos_x,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic                                  inside_res
);

	localparam int NV = pit_pkg::NUM_VERTS;
	localparam int NA = pit_pkg::NUM_AXES;

	pit_pkg::coord_t vert_q [NV][NA];
	pit_pkg::coord_t pt     [NA];
	pit_pkg::coord_t rows   [NV][NV][NA];
	pit_pkg::diff_t  diff   [NV][NA][NA];

	pit_pkg::diff_t     d_s1   [NV][NA][NA];
	pit_pkg::prod_t     pa_s2  [NV][NA];
	pit_pkg::prod_t     pb_s2  [NV][NA];
	pit_pkg::diff_t     r0_s2  [NV][NA];
	pit_pkg::minor_t    m_s3   [NV][NA];
	pit_pkg::diff_t     r0_s3  [NV][NA];
	pit_pkg::plo_t      plo_s4 [NV][NA];
	pit_pkg::phi_t      phi_s4 [NV][NA];
	pit_pkg::term_t     t_s5   [NV][NA];
	logic               inside_s6;

	pit_pkg::det_t      det    [NV];
	logic [NV-1:0]      neg;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;
	logic acc;

	// each stage moves when empty or when the one after it moves
	assign en6 = !v_s6 || out_ready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;

	assign in_ready   = en1;
	assign acc        = in_valid && en1;
	assign out_valid  = v_s6;
	assign inside_res = inside_s6;

	assign pt[0] = pos_z;
	assign pt[1] = pos_y;
	assign pt[2] = pos_x;

	// vertex rows with row l replaced by the point, then differences to row 0
	always_comb begin
		for (int l = 0; l < NV; l++) begin
			for (int i = 0; i < NV; i++) begin
				for (int k = 0; k < NA; k++) begin
					rows[l][i][k] = (i == l) ? pt[k] : vert_q[i][k];
				end
			end
			for (int i = 0; i < NA; i++) begin
				for (int k = 0; k < NA; k++) begin
					diff[l][i][k] = pit_pkg::diff_t'(rows[l][i+1][k])
						- pit_pkg::diff_t'(rows[l][0][k]);
				end
			end
		end
	end

	// final sum and sign
	always_comb begin
		for (int l = 0; l < NV; l++) begin
			det[l] = pit_pkg::det_t'(t_s5[l][0]) - pit_pkg::det_t'(t_s5[l][1])
				+ pit_pkg::det_t'(t_s5[l][2]);
			neg[l] = det[l][pit_pkg::DETW-1];
		end
	end

	always_ff @(posedge clk) begin
		if (acc && command == pit_pkg::CMD_LOAD) begin
			vert_q[vertex_index][0] <= pos_z;
			vert_q[vertex_index][1] <= pos_y;
			vert_q[vertex_index][2] <= pos_x;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			d_s1 <= diff;
		end
		if (en2) begin
			for (int l = 0; l < NV; l++) begin
				pa_s2[l][0] <= pit_pkg::prod_t'(d_s1[l][1][1]) * pit_pkg::prod_t'(d_s1[l][2][2]);
				pb_s2[l][0] <= pit_pkg::prod_t'(d_s1[l][1][2]) * pit_pkg::prod_t'(d_s1[l][2][1]);
				pa_s2[l][1] <= pit_pkg::prod_t'(d_s1[l][1][0]) * pit_pkg::prod_t'(d_s1[l][2][2]);
				pb_s2[l][1] <= pit_pkg::prod_t'(d_s1[l][1][2]) * pit_pkg::prod_t'(d_s1[l][2][0]);
				pa_s2[l][2] <= pit_pkg::prod_t'(d_s1[l][1][0]) * pit_pkg::prod_t'(d_s1[l][2][1]);
				pb_s2[l][2] <= pit_pkg::prod_t'(d_s1[l][1][1]) * pit_pkg::prod_t'(d_s1[l][2][0]);
				for (int k = 0; k < NA; k++) begin
					r0_s2[l][k] <= d_s1[l][0][k];
				end
			end
		end
		if (en3) begin
			for (int l = 0; l < NV; l++) begin
				for (int k = 0; k < NA; k++) begin
					m_s3[l][k]  <= pit_pkg::minor_t'(pa_s2[l][k])
						- pit_pkg::minor_t'(pb_s2[l][k]);
					r0_s3[l][k] <= r0_s2[l][k];
				end
			end
		end
		if (en4) begin
			for (int l = 0; l < NV; l++) begin
				for (int k = 0; k < NA; k++) begin
					plo_s4[l][k] <= pit_pkg::plo_t'(r0_s3[l][k])
						* pit_pkg::plo_t'($signed({1'b0,
							pit_pkg::minor_lo_t'(m_s3[l][k][pit_pkg::LO_W-1:0])}));
					phi_s4[l][k] <= pit_pkg::phi_t'(r0_s3[l][k])
						* pit_pkg::phi_t'($signed(m_s3[l][k][pit_pkg::MW-1:pit_pkg::LO_W]));
				end
			end
		end
		if (en5) begin
			for (int l = 0; l < NV; l++) begin
				for (int k = 0; k < NA; k++) begin
					t_s5[l][k] <= (pit_pkg::term_t'(phi_s4[l][k]) <<< pit_pkg::LO_W)
						+ pit_pkg::term_t'(plo_s4[l][k]);
				end
			end
		end
		if (en6) begin
			inside_s6 <= !(|neg);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid && command == pit_pkg::CMD_TEST;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
			if (en5) begin
				v_s5 <= v_s4;
			end
			if (en6) begin
				v_s6 <= v_s5;
			end
		end
	end

endmodule

`default_nettype wire

### hw/rtl/pit_chk.sv
// ---------------------------------------------------------------------------
// pit_chk
// port-level checks of the point-in-tetrahedron test block
// ---------------------------------------------------------------------------
`default_nettype none

`include "point_in_tetrahedron_test_top_defines.svh"

module pit_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready
);

	// a pending result transaction stays offered
	`PIT_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)

	// with the output drained every stage can move, so input is taken
	`PIT_ASSERT_IMP(a_ready_pass, clk, arst_n, out_ready, in_ready)

	// no result can reach the output sooner than the pipeline depth after reset
	`PIT_ASSERT_IMP(a_reset_empty, clk, arst_n, !$past(arst_n, 5), !out_valid)

endmodule

bind point_in_tetrahedron_test_top pit_chk u_pit_chk (.*);

`default_nettype wire
